[sv/assert_macros.svh]
// Assertion macros shared by the renumbering RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/g2l_pkg.sv]
// Types and constants of the global-to-local index renumbering block.
`timescale 1ns / 1ps

package g2l_pkg;

    localparam int GIDX_W     = 32;
    localparam int SLOT_W     = 8;
    localparam int CNT_OUT_W  = 9;
    localparam int MODE_W     = 2;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 56;

    // Input tdata bit positions
    localparam int IN_START_BIT = 0;
    localparam int IN_GIDX_LSB  = 1;
    localparam int IN_SLOT_LSB  = 33;

    // Mode codes as seen on the stream
    localparam logic [MODE_W-1:0] MODE_ROW  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_COL  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ = 2'd2;

    typedef enum logic [1:0] {
        OP_ROW,
        OP_COL,
        OP_READ,
        OP_NONE
    } t_op;

    typedef struct packed {
        t_op                op;
        logic               start;
        logic [GIDX_W-1:0]  gidx;
        logic [SLOT_W-1:0]  squery;
    } t_cmd;

    typedef struct packed {
        logic                  overflow;
        logic [GIDX_W-1:0]     table_value;
        logic [CNT_OUT_W-1:0]  entry_count;
        logic                  was_new;
        logic [SLOT_W-1:0]     local_index;
    } t_result;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_READ_WAIT,
        S_DONE
    } t_state;

endpackage

[sv/g2l_front.sv]
// Front end: takes input transfers, decodes the mode and pushes commands.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module g2l_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [g2l_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    input  logic [g2l_pkg::MODE_W-1:0]          s_axis_tuser,
    input  logic                                i_q_full,
    output logic                                o_q_push,
    output g2l_pkg::t_cmd                       o_q_cmd
);

    // No transfer is taken while reset is held
    assign s_axis_tready = i_rst_n && !i_q_full;
    assign o_q_push      = s_axis_tvalid && s_axis_tready;

    always_comb begin
        case (s_axis_tuser)
            g2l_pkg::MODE_ROW:  o_q_cmd.op = g2l_pkg::OP_ROW;
            g2l_pkg::MODE_COL:  o_q_cmd.op = g2l_pkg::OP_COL;
            g2l_pkg::MODE_READ: o_q_cmd.op = g2l_pkg::OP_READ;
            default:            o_q_cmd.op = g2l_pkg::OP_NONE;
        endcase
        o_q_cmd.start  = s_axis_tdata[g2l_pkg::IN_START_BIT];
        o_q_cmd.gidx   = s_axis_tdata[g2l_pkg::IN_GIDX_LSB +: g2l_pkg::GIDX_W];
        o_q_cmd.squery = s_axis_tdata[g2l_pkg::IN_SLOT_LSB +: g2l_pkg::SLOT_W];
    end

    `ASSERT_CLK(a_push_ready, i_clk, i_rst_n,
        o_q_push == (s_axis_tvalid && s_axis_tready),
        "front push disagrees with input handshake")
    `ASSERT_CLK(a_no_push_full, i_clk, i_rst_n, o_q_push |-> !i_q_full,
        "push into a full command queue")
    `ASSERT_CLK(a_ready_room, i_clk, i_rst_n, s_axis_tready |-> !i_q_full,
        "input ready while command queue is full")

endmodule

[sv/g2l_queue.sv]
// Two-entry command queue between front end and back end.
`timescale 1ns / 1ps

module g2l_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  g2l_pkg::t_cmd  i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output g2l_pkg::t_cmd  o_cmd,
    output logic           o_empty
);

    g2l_pkg::t_cmd r_mem [2];
    logic          r_wr_ptr;
    logic          r_rd_ptr;
    logic [1:0]    r_fill;
    logic [1:0]    n_fill;

    assign o_full  = (r_fill == 2'd2);
    assign o_empty = (r_fill == 2'd0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_comb begin
        n_fill = r_fill;
        if (i_push && !i_pop) begin
            n_fill = r_fill + 2'd1;
        end else if (i_pop && !i_push) begin
            n_fill = r_fill - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            r_fill <= n_fill;
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

[sv/g2l_back.sv]
// Back end: table memory, row/column renumbering sequencer and result register.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module g2l_back #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_empty,
    input  g2l_pkg::t_cmd     i_q_cmd,
    output logic              o_q_pop,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output g2l_pkg::t_result  o_res
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    g2l_pkg::t_state  r_state, n_state;
    g2l_pkg::t_cmd    r_cmd, n_cmd;
    g2l_pkg::t_result r_res, n_res;
    g2l_pkg::t_result r_out, n_out;
    logic             r_out_valid, n_out_valid;
    logic [CW-1:0]    r_count, n_count;
    logic [31:0]      r_prev_row, n_prev_row;
    logic             r_prev_valid, n_prev_valid;
    logic [AW-1:0]    r_k, n_k;

    logic [31:0]      r_mem [TABLE_DEPTH];
    logic [31:0]      r_rd_data;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;

    logic             has_room;
    logic             append_req;
    logic             row_hit;
    logic [CW-1:0]    k_next;
    logic [CW-1:0]    cnt_m1;
    logic [AW+7:0]    k_wide;
    logic [CW+7:0]    cnt_wide;
    logic [CW+7:0]    cnt_m1_wide;
    logic [CW+8:0]    cnt9_wide;
    logic [AW+7:0]    sq_wide;
    logic             sq_in_range;

    assign has_room    = r_count < CW'(TABLE_DEPTH);
    assign k_next      = CW'(r_k) + CW'(1);
    assign cnt_m1      = r_count - CW'(1);
    assign k_wide      = {8'd0, r_k};
    assign cnt_wide    = {8'd0, r_count};
    assign cnt_m1_wide = {8'd0, cnt_m1};
    assign cnt9_wide   = {9'd0, r_count};
    assign sq_wide     = {{AW{1'b0}}, r_cmd.squery};
    assign sq_in_range = sq_wide < (AW + 8)'(TABLE_DEPTH);
    assign row_hit     = r_prev_valid && (r_cmd.gidx == r_prev_row) && (r_count != '0);
    assign wr_addr     = r_count[AW-1:0];

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_res        = r_res;
        n_out        = r_out;
        n_out_valid  = r_out_valid;
        n_count      = r_count;
        n_prev_row   = r_prev_row;
        n_prev_valid = r_prev_valid;
        n_k          = r_k;
        o_q_pop      = 1'b0;
        rd_en        = 1'b0;
        rd_addr      = r_k;
        wr_en        = 1'b0;
        append_req   = 1'b0;

        if (r_out_valid && i_res_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            g2l_pkg::S_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_cmd   = i_q_cmd;
                    if (i_q_cmd.start) begin
                        n_count      = '0;
                        n_prev_valid = 1'b0;
                    end
                    n_state = g2l_pkg::S_DISPATCH;
                end
            end
            g2l_pkg::S_DISPATCH: begin
                n_res = '0;
                case (r_cmd.op)
                    g2l_pkg::OP_ROW: begin
                        if (row_hit) begin
                            n_res.local_index = cnt_m1_wide[7:0];
                        end else begin
                            append_req = 1'b1;
                        end
                        n_prev_row   = r_cmd.gidx;
                        n_prev_valid = row_hit || has_room;
                        n_state      = g2l_pkg::S_DONE;
                    end
                    g2l_pkg::OP_COL: begin
                        n_k = '0;
                        if (r_count == '0) begin
                            append_req = 1'b1;
                            n_state    = g2l_pkg::S_DONE;
                        end else begin
                            n_state = g2l_pkg::S_SCAN_RD;
                        end
                    end
                    g2l_pkg::OP_READ: begin
                        rd_en             = 1'b1;
                        rd_addr           = sq_wide[AW-1:0];
                        n_res.local_index = r_cmd.squery;
                        n_state           = g2l_pkg::S_READ_WAIT;
                    end
                    default: begin
                        n_state = g2l_pkg::S_DONE;
                    end
                endcase
            end
            g2l_pkg::S_SCAN_RD: begin
                rd_en   = 1'b1;
                rd_addr = r_k;
                n_state = g2l_pkg::S_SCAN_CMP;
            end
            g2l_pkg::S_SCAN_CMP: begin
                if (r_rd_data == r_cmd.gidx) begin
                    n_res.local_index = k_wide[7:0];
                    n_state           = g2l_pkg::S_DONE;
                end else if (k_next == r_count) begin
                    append_req = 1'b1;
                    n_state    = g2l_pkg::S_DONE;
                end else begin
                    n_k     = r_k + AW'(1);
                    n_state = g2l_pkg::S_SCAN_RD;
                end
            end
            g2l_pkg::S_READ_WAIT: begin
                n_res.table_value = sq_in_range ? r_rd_data : 32'd0;
                n_state           = g2l_pkg::S_DONE;
            end
            g2l_pkg::S_DONE: begin
                if (!r_out_valid || i_res_ready) begin
                    n_out             = r_res;
                    n_out.entry_count = cnt9_wide[8:0];
                    n_out_valid       = 1'b1;
                    n_state           = g2l_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = g2l_pkg::S_IDLE;
            end
        endcase

        // Append shared by row miss, empty column table and column scan miss
        if (append_req) begin
            if (has_room) begin
                wr_en             = 1'b1;
                n_res.local_index = cnt_wide[7:0];
                n_res.was_new     = 1'b1;
                n_count           = r_count + CW'(1);
            end else begin
                n_res.local_index = 8'd0;
                n_res.overflow    = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= g2l_pkg::S_IDLE;
            r_count      <= '0;
            r_prev_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_prev_valid <= n_prev_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_res      <= n_res;
        r_out      <= n_out;
        r_prev_row <= n_prev_row;
        r_k        <= n_k;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= r_cmd.gidx;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    `ASSERT_CLK(a_count_bound, i_clk, i_rst_n, r_count <= CW'(TABLE_DEPTH),
        "entry count beyond table depth")
    `ASSERT_CLK(a_write_room, i_clk, i_rst_n, wr_en |-> has_room,
        "table write with no free slot")
    `ASSERT_CLK(a_scan_range, i_clk, i_rst_n,
        (r_state == g2l_pkg::S_SCAN_RD) |-> (CW'(r_k) < r_count),
        "column scan beyond filled slots")
    `ASSERT_NEXT(a_append_grows, i_clk, i_rst_n, wr_en, r_count == $past(r_count) + CW'(1),
        "append did not advance entry count")
    `ASSERT_CLK(a_flags_excl, i_clk, i_rst_n, r_out_valid |-> !(r_out.was_new && r_out.overflow),
        "result both appended and refused")

endmodule

[sv/global_to_local_index_renumber_top.sv]
// Top level of the global-to-local index renumbering block.
`timescale 1ns / 1ps

// Global-to-local index renumbering: each input transfer carries one global vertex
// number (or a slot query) and yields exactly one result transfer with the dense
// local slot, a new-entry flag, the running entry count, the stored global number
// (read mode) and an overflow flag. start_req clears the count and the previous
// row before its own item. A front end decodes input transfers into a two-entry
// command queue, so the input side keeps taking transfers while the back end works
// or a result waits, as long as the queue has room; the back end holds the table
// in a single-port memory of TABLE_DEPTH x 32 bits and a one-entry output register.
// Every item passes the back end's idle, dispatch and done states; read mode adds
// a read-wait state, and column mode adds a scan-read and a scan-compare state for
// each table slot compared up to and including the first match (every filled slot
// on a miss, none for an empty table). The scan reads one table entry per memory
// access and compares it in the next cycle. The table needs no clearing after
// reset: only slots below the entry count are ever searched.
module global_to_local_index_renumber_top #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [0] start_req, [32:1] global_index, [40:33] slot_query, [47:41] zero
    input  logic [g2l_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    // [1:0] mode
    input  logic [g2l_pkg::MODE_W-1:0]          s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [7:0] local_index, [8] was_new, [17:9] entry_count,
    // [49:18] table_value, [50] overflow, [55:51] zero
    output logic [g2l_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);

    g2l_pkg::t_cmd    front_cmd;
    g2l_pkg::t_cmd    queue_cmd;
    g2l_pkg::t_result result;
    logic             q_push;
    logic             q_full;
    logic             q_pop;
    logic             q_empty;

    g2l_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_q_full      (q_full),
        .o_q_push      (q_push),
        .o_q_cmd       (front_cmd)
    );

    g2l_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_cmd   (queue_cmd),
        .o_empty (q_empty)
    );

    g2l_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_q_cmd     (queue_cmd),
        .o_q_pop     (q_pop),
        .o_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .o_res       (result)
    );

    // Result struct is declared high field first, so it packs straight into tdata
    assign m_axis_tdata = {5'd0, result};

endmodule

[bench/global_to_local_index_renumber_top_tb.sv]
// Self-checking testbench for the global-to-local index renumbering block.
`timescale 1ns / 1ps

module global_to_local_index_renumber_top_tb;

    localparam int          TABLE_DEPTH  = 256;
    localparam int          MAX_WAIT     = 14;
    localparam int          RANDOM_ITEMS = 2000;
    localparam int          HOLD_AT      = 500;   // result count that triggers the long hold-off
    localparam int          HOLD_CYCLES  = 400;
    localparam int          DRAIN_CYCLES = 32;
    localparam longint      CYCLE_LIMIT  = 5_000_000;

    localparam int          GIDX_W       = g2l_pkg::GIDX_W;
    localparam int          SLOT_W       = g2l_pkg::SLOT_W;
    localparam int          CNT_OUT_W    = g2l_pkg::CNT_OUT_W;
    localparam int          MODE_W       = g2l_pkg::MODE_W;
    localparam int          IN_DATA_W    = g2l_pkg::IN_DATA_W;
    localparam int          OUT_DATA_W   = g2l_pkg::OUT_DATA_W;

    // One edge-endpoint transfer together with the result it must produce.
    typedef struct {
        g2l_pkg::t_op       op;
        bit                 start;
        logic [GIDX_W-1:0]  gidx;
        logic [SLOT_W-1:0]  squery;
        g2l_pkg::t_result   want;
    } t_edge_item;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata  = '0;
    logic [MODE_W-1:0]      s_axis_tuser  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;

    global_to_local_index_renumber_top #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #1 i_clk = ~i_clk;

    // Shadow of the renumbering state, advanced in transfer order.
    logic [GIDX_W-1:0]  shadow_slots [TABLE_DEPTH];
    int unsigned        fill_count     = 0;
    int unsigned        high_water     = 0;   // slots below this were written at least once
    logic [GIDX_W-1:0]  last_row       = '0;
    bit                 last_row_valid = 1'b0;

    int unsigned n_row = 0, n_col = 0, n_read = 0, n_unused = 0;
    int unsigned n_refused = 0, n_starts = 0;

    t_edge_item        pending_items [$];
    g2l_pkg::t_result  renumber_expected [$];
    int unsigned items_sent   = 0;
    int unsigned results_seen = 0;
    int unsigned err_count    = 0;

    function automatic void store_new(input logic [GIDX_W-1:0] gidx,
                                      inout g2l_pkg::t_result r);
        if (fill_count < TABLE_DEPTH) begin
            shadow_slots[fill_count] = gidx;
            r.local_index = SLOT_W'(fill_count);
            r.was_new = 1'b1;
            fill_count++;
            if (fill_count > high_water) high_water = fill_count;
        end else begin
            r.overflow = 1'b1;
            n_refused++;
        end
    endfunction

    function automatic g2l_pkg::t_result renumber_predict(input g2l_pkg::t_op op,
                                                          input bit start,
                                                          input logic [GIDX_W-1:0] gidx,
                                                          input logic [SLOT_W-1:0] squery);
        g2l_pkg::t_result r;
        bit               hit;
        r = '0;
        hit = 1'b0;
        if (start) begin
            fill_count = 0;
            last_row_valid = 1'b0;
            n_starts++;
        end
        case (op)
            g2l_pkg::OP_ROW: begin
                n_row++;
                if (last_row_valid && gidx == last_row && fill_count > 0) begin
                    r.local_index = SLOT_W'(fill_count - 1);
                end else begin
                    store_new(gidx, r);
                end
                last_row = gidx;
                // a refused row is refused again when repeated
                last_row_valid = !r.overflow;
            end
            g2l_pkg::OP_COL: begin
                n_col++;
                for (int k = 0; k < fill_count; k++) begin
                    if (!hit && shadow_slots[k] == gidx) begin
                        hit = 1'b1;
                        r.local_index = SLOT_W'(k);
                    end
                end
                if (!hit) store_new(gidx, r);
            end
            g2l_pkg::OP_READ: begin
                n_read++;
                r.local_index = squery;
                r.table_value = shadow_slots[squery];
            end
            default: begin
                n_unused++;
            end
        endcase
        r.entry_count = CNT_OUT_W'(fill_count);
        return r;
    endfunction

    task automatic queue_item(input g2l_pkg::t_op op, input bit start,
                              input logic [GIDX_W-1:0] gidx,
                              input logic [SLOT_W-1:0] squery);
        t_edge_item it;
        it.op = op;
        it.start = start;
        it.gidx = gidx;
        it.squery = squery;
        it.want = renumber_predict(op, start, gidx, squery);
        pending_items.push_back(it);
    endtask

    // Global numbers biased toward extremes and a small range that collides often.
    function automatic logic [GIDX_W-1:0] fresh_gidx();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 3) return '0;
        if (pick < 6) return '1;
        if (pick < 8) return 32'h8000_0000;
        if (pick < 25) return GIDX_W'($urandom_range(0, 15));
        return $urandom;
    endfunction

    task automatic queue_random(input bit first, input int unsigned reuse_pct, input bit noisy);
        int unsigned       pick;
        g2l_pkg::t_op      op;
        bit                start;
        logic [GIDX_W-1:0] gidx;
        logic [SLOT_W-1:0] squery;
        pick = $urandom_range(0, 99);
        op = (pick < 45) ? g2l_pkg::OP_ROW :
             (pick < 85) ? g2l_pkg::OP_COL :
             (pick < 95) ? g2l_pkg::OP_READ : g2l_pkg::OP_NONE;
        if (op == g2l_pkg::OP_READ && high_water == 0) op = g2l_pkg::OP_COL;
        start = first || (noisy && $urandom_range(0, 49) == 0);
        gidx = $urandom;
        squery = SLOT_W'($urandom_range(0, 255));
        case (op)
            g2l_pkg::OP_ROW: begin
                if ($urandom_range(0, 99) < reuse_pct) begin
                    gidx = last_row;
                end else if (fill_count > 0 && $urandom_range(0, 3) == 0) begin
                    gidx = shadow_slots[$urandom_range(0, fill_count - 1)];
                end else begin
                    gidx = fresh_gidx();
                end
            end
            g2l_pkg::OP_COL: begin
                if (fill_count > 0 && $urandom_range(0, 99) < reuse_pct) begin
                    gidx = shadow_slots[$urandom_range(0, fill_count - 1)];
                end else begin
                    gidx = fresh_gidx();
                end
            end
            g2l_pkg::OP_READ: begin
                // only slots that were written at some point are read
                pick = $urandom_range(0, 99);
                if (pick < 20) begin
                    squery = SLOT_W'(high_water - 1);
                end else if (pick < 30) begin
                    squery = '0;
                end else begin
                    squery = SLOT_W'($urandom_range(0, high_water - 1));
                end
            end
            default: ;
        endcase
        queue_item(op, start, gidx, squery);
    endtask

    // Per-transfer wait, with occasional stretches of back-to-back traffic.
    function automatic int unsigned draw_wait(inout int unsigned calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 29) == 0) calm = $urandom_range(20, 80);
        return $urandom_range(0, MAX_WAIT);
    endfunction

    task automatic check_result(input g2l_pkg::t_result want, input g2l_pkg::t_result got);
        if (got.local_index !== want.local_index) begin
            $error("local_index: expected %0d, got %0d", want.local_index, got.local_index);
            err_count++;
        end
        if (got.was_new !== want.was_new) begin
            $error("was_new: expected %0d, got %0d", want.was_new, got.was_new);
            err_count++;
        end
        if (got.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d", want.entry_count, got.entry_count);
            err_count++;
        end
        if (got.table_value !== want.table_value) begin
            $error("table_value: expected %h, got %h", want.table_value, got.table_value);
            err_count++;
        end
        if (got.overflow !== want.overflow) begin
            $error("overflow: expected %0d, got %0d", want.overflow, got.overflow);
            err_count++;
        end
    endtask

    // Input side: presents queued transfers with random gaps between them.
    int unsigned       send_gap  = 0;
    int unsigned       send_calm = 0;
    g2l_pkg::t_result  offered_want;

    always @(posedge i_clk) begin : edge_driver
        t_edge_item it;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                renumber_expected.push_back(offered_want);
                items_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    it = pending_items.pop_front();
                    s_axis_tdata <= IN_DATA_W'({it.squery, it.gidx, it.start});
                    s_axis_tuser <= it.op;
                    s_axis_tvalid <= 1'b1;
                    offered_want = it.want;
                    send_gap = draw_wait(send_calm);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result side: checks each transfer, stalls at random, and once holds off long
    // enough for the block to back up into its input.
    int unsigned recv_stall = 0;
    int unsigned recv_calm  = 0;
    int unsigned hold_left  = 0;
    bit          hold_done  = 1'b0;

    always @(posedge i_clk) begin : result_monitor
        g2l_pkg::t_result got;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = g2l_pkg::t_result'(m_axis_tdata[$bits(g2l_pkg::t_result)-1:0]);
                results_seen++;
                if (renumber_expected.size() == 0) begin
                    $error("result transfer with no expected result pending");
                    err_count++;
                end else begin
                    check_result(renumber_expected.pop_front(), got);
                end
                recv_stall = draw_wait(recv_calm);
                if (!hold_done && results_seen == HOLD_AT) begin
                    hold_left = HOLD_CYCLES;
                    hold_done = 1'b1;
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (recv_stall > 0) begin
                recv_stall--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    longint unsigned cycle_count = 0;

    always @(posedge i_clk) begin : watchdog
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("global_to_local_index_renumber_top regression: fail");
            $finish;
        end
    end

    initial begin : stimulus
        int unsigned random_queued;
        int unsigned batch_no;
        int unsigned batch_len;
        int unsigned total;
        bit          deep;

        // Directed: extremes, repeats, every mode, starts in several modes.
        // The full-table case is reached by the deep random batches below.
        queue_item(g2l_pkg::OP_ROW,  1'b1, 32'h0000_0000, 8'd0);    // first row of a batch
        queue_item(g2l_pkg::OP_ROW,  1'b0, 32'h0000_0000, 8'd255);  // repeated row, same slot
        queue_item(g2l_pkg::OP_ROW,  1'b0, 32'hFFFF_FFFF, 8'd0);
        queue_item(g2l_pkg::OP_ROW,  1'b0, 32'hFFFF_FFFF, 8'd0);
        queue_item(g2l_pkg::OP_COL,  1'b0, 32'h0000_0000, 8'd0);    // hit in first slot
        queue_item(g2l_pkg::OP_COL,  1'b0, 32'hFFFF_FFFF, 8'd255);
        queue_item(g2l_pkg::OP_COL,  1'b0, 32'hA5A5_5A5A, 8'd0);    // miss, appended
        queue_item(g2l_pkg::OP_COL,  1'b0, 32'hA5A5_5A5A, 8'd0);
        queue_item(g2l_pkg::OP_ROW,  1'b0, 32'hA5A5_5A5A, 8'd0);    // differs from last row
        queue_item(g2l_pkg::OP_READ, 1'b0, 32'hFFFF_FFFF, 8'd0);
        queue_item(g2l_pkg::OP_READ, 1'b0, 32'h0000_0000, 8'd3);
        queue_item(g2l_pkg::OP_NONE, 1'b0, 32'h1234_5678, 8'd7);
        queue_item(g2l_pkg::OP_ROW,  1'b1, 32'h0000_0000, 8'd0);    // restart overwrites slot 0
        queue_item(g2l_pkg::OP_COL,  1'b0, 32'hFFFF_FFFF, 8'd0);    // stale slots not searched
        queue_item(g2l_pkg::OP_READ, 1'b0, 32'h0000_0000, 8'd3);    // stale slot still readable
        queue_item(g2l_pkg::OP_NONE, 1'b1, 32'hFFFF_FFFF, 8'd255);  // start via unused mode
        queue_item(g2l_pkg::OP_ROW,  1'b0, 32'h0000_0000, 8'd0);    // same as last row, none valid
        queue_item(g2l_pkg::OP_READ, 1'b1, 32'h0000_0000, 8'd1);
        queue_item(g2l_pkg::OP_COL,  1'b1, 32'h1234_5678, 8'd0);    // column on an empty table
        queue_item(g2l_pkg::OP_COL,  1'b0, 32'h1234_5678, 8'd0);

        // Random batches; two deep ones fill the table and run into overflow.
        random_queued = 0;
        batch_no = 0;
        while (random_queued < RANDOM_ITEMS) begin
            deep = (batch_no == 4 || batch_no == 30);
            batch_len = deep ? 480 : $urandom_range(4, 40);
            for (int i = 0; i < batch_len; i++) begin
                queue_random(i == 0, deep ? 10 : 60, !deep);
            end
            random_queued += batch_len;
            batch_no++;
        end
        total = pending_items.size();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (items_sent < total || renumber_expected.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Checked %0d results: %0d row, %0d column, %0d read, %0d unused-mode transfers.",
                 results_seen, n_row, n_col, n_read, n_unused);
        $display("%0d batch starts, %0d appends refused on a full table, %0d slots ever filled.",
                 n_starts, n_refused, high_water);
        if (err_count == 0 && renumber_expected.size() == 0) begin
            $display("global_to_local_index_renumber_top regression: pass");
        end else begin
            $display("global_to_local_index_renumber_top regression: fail");
        end
        $finish;
    end

endmodule
